// ===== rtl/core/psf_pkg.sv =====
package psf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int OUT_BITS    = 25;
	localparam int COEF_BITS   = 8;
	localparam int DEN_BITS    = 7;
	localparam int TAPS        = 7;

	// sum of coefficient magnitudes never reaches 128
	localparam int MAG_BITS  = SAMPLE_BITS + 7;
	localparam int SUM_BITS  = MAG_BITS + 1;
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int V_BITS    = DEN_BITS + FRAC_BITS + 2;
	localparam int Q_BITS    = MAG_BITS + FRAC_BITS + 1;

	// reciprocal scaling for exact floor division by the odd part of a divisor
	localparam int K1 = MAG_BITS + 6;
	localparam int K2 = V_BITS + 6;

	localparam int JQ_DEPTH = 2;
	localparam int OQ_DEPTH = 16;

	// configuration register indexes
	localparam logic REG_WINDOW_POINTS = 1'b0;
	localparam logic REG_FIT_ORDER     = 1'b1;

	// odd factor of a divisor
	localparam logic [2:0] ODD_1  = 3'd0;
	localparam logic [2:0] ODD_5  = 3'd1;
	localparam logic [2:0] ODD_7  = 3'd2;
	localparam logic [2:0] ODD_21 = 3'd3;
	localparam logic [2:0] ODD_35 = 3'd4;

	localparam logic [K1:0] R1_1  = (K1+1)'(64'd1 << K1);
	localparam logic [K1:0] R1_5  = (K1+1)'(((64'd1 << K1) + 64'd4) / 64'd5);
	localparam logic [K1:0] R1_7  = (K1+1)'(((64'd1 << K1) + 64'd6) / 64'd7);
	localparam logic [K1:0] R1_21 = (K1+1)'(((64'd1 << K1) + 64'd20) / 64'd21);
	localparam logic [K1:0] R1_35 = (K1+1)'(((64'd1 << K1) + 64'd34) / 64'd35);

	localparam logic [K2:0] R2_1  = (K2+1)'(64'd1 << K2);
	localparam logic [K2:0] R2_5  = (K2+1)'(((64'd1 << K2) + 64'd4) / 64'd5);
	localparam logic [K2:0] R2_7  = (K2+1)'(((64'd1 << K2) + 64'd6) / 64'd7);
	localparam logic [K2:0] R2_21 = (K2+1)'(((64'd1 << K2) + 64'd20) / 64'd21);
	localparam logic [K2:0] R2_35 = (K2+1)'(((64'd1 << K2) + 64'd34) / 64'd35);

	// [order][size][row][tap]
	localparam logic signed [COEF_BITS-1:0] HEAD_COEF [3][2][3][TAPS] = '{
		'{ '{ '{3, 2, 1, 0, -1, 0, 0}, '{4, 3, 2, 1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0} },
		   '{ '{13, 10, 7, 4, 1, -2, -5}, '{5, 4, 3, 2, 1, 0, -1}, '{7, 6, 5, 4, 3, 2, 1} } },
		'{ '{ '{31, 9, -3, -5, 3, 0, 0}, '{9, 13, 12, 6, -5, 0, 0}, '{0, 0, 0, 0, 0, 0, 0} },
		   '{ '{32, 15, 3, -4, -6, -3, 5}, '{5, 4, 3, 2, 1, 0, -1}, '{1, 3, 4, 4, 3, 1, -2} } },
		'{ '{ '{69, 4, -6, 4, -1, 0, 0}, '{2, 27, 12, -8, 2, 0, 0}, '{0, 0, 0, 0, 0, 0, 0} },
		   '{ '{39, 8, -4, -4, 1, 4, -2}, '{8, 19, 16, 6, -4, -7, 4},
		      '{-4, 16, 19, 12, 2, -4, 1} } }
	};
	localparam logic [DEN_BITS-1:0] HEAD_DEN [3][2][3] = '{
		'{ '{5, 10, 1}, '{28, 14, 28} },
		'{ '{35, 35, 1}, '{42, 14, 14} },
		'{ '{70, 35, 1}, '{42, 42, 42} }
	};
	localparam logic signed [COEF_BITS-1:0] MID_COEF [3][2][TAPS] = '{
		'{ '{1, 1, 1, 1, 1, 0, 0}, '{1, 1, 1, 1, 1, 1, 1} },
		'{ '{-3, 12, 17, 12, -3, 0, 0}, '{-2, 3, 6, 7, 6, 3, -2} },
		'{ '{-3, 12, 17, 12, -3, 0, 0}, '{-2, 3, 6, 7, 6, 3, -2} }
	};
	localparam logic [DEN_BITS-1:0] MID_DEN [3][2] = '{ '{5, 7}, '{35, 21}, '{35, 21} };

	typedef struct packed {
		logic [TAPS-1:0][SAMPLE_BITS-1:0] win;
		logic                             sz;
		logic [1:0]                       ord;
		logic                             pass;
		logic [2:0]                       npass;
		logic                             head;
		logic                             last;
	} job_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] smoothed;
		logic                       eow;
	} res_t;

	function automatic logic [1:0] den_shift(input logic [DEN_BITS-1:0] den);
		logic [1:0] k;
		case (den)
			7'd10, 7'd14, 7'd42, 7'd70: k = 2'd1;
			7'd28:                      k = 2'd2;
			default:                    k = 2'd0;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] den_odd(input logic [DEN_BITS-1:0] den);
		logic [2:0] o;
		case (den)
			7'd5, 7'd10:         o = ODD_5;
			7'd7, 7'd14, 7'd28:  o = ODD_7;
			7'd21, 7'd42:        o = ODD_21;
			7'd35, 7'd70:        o = ODD_35;
			default:             o = ODD_1;
		endcase
		return o;
	endfunction

	function automatic logic [K1:0] recip1(input logic [2:0] o);
		logic [K1:0] r;
		case (o)
			ODD_5:   r = R1_5;
			ODD_7:   r = R1_7;
			ODD_21:  r = R1_21;
			ODD_35:  r = R1_35;
			default: r = R1_1;
		endcase
		return r;
	endfunction

	function automatic logic [K2:0] recip2(input logic [2:0] o);
		logic [K2:0] r;
		case (o)
			ODD_5:   r = R2_5;
			ODD_7:   r = R2_7;
			ODD_21:  r = R2_21;
			ODD_35:  r = R2_35;
			default: r = R2_1;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/psf_front.sv =====
module psf_front import psf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_sample,
	input  logic                   sz,
	input  logic [1:0]             ord,
	output logic                   jq_push,
	output job_t                   jq_din
);

	logic [TAPS-1:0][SAMPLE_BITS-1:0] win_q;
	logic [2:0]                       cnt_q;
	logic [2:0]                       cnt_nx;
	logic [2:0]                       w;
	logic                             accept;

	assign accept = push && !full;

	always_comb begin
		cnt_nx = (cnt_q == 3'd7) ? 3'd7 : cnt_q + 3'd1;
		w      = sz ? 3'd7 : 3'd5;
		for (int p = 0; p < TAPS - 1; p++) begin
			jq_din.win[p] = win_q[p+1];
		end
		jq_din.win[TAPS-1] = sample;
		jq_din.sz    = sz;
		jq_din.ord   = (ord == 2'd3) ? 2'd2 : ord;
		jq_din.pass  = cnt_nx < w;
		jq_din.npass = cnt_nx;
		jq_din.head  = (cnt_q == w - 3'd1) && !(cnt_nx < w);
		jq_din.last  = last_sample;
		// short waveform only emits when it ends
		jq_push = accept && (!(cnt_nx < w) || last_sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last_sample) begin
				win_q <= '0;
				cnt_q <= '0;
			end else begin
				win_q <= jq_din.win;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule

// ===== rtl/core/psf_jobq.sv =====
module psf_jobq import psf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);

	localparam int PW = $clog2(JQ_DEPTH);
	localparam int CW = $clog2(JQ_DEPTH + 1);

	job_t          mem_q [JQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(JQ_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(JQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(JQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ===== rtl/core/psf_back.sv =====
module psf_back import psf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  job_t                       job,
	input  logic                       job_empty,
	output logic                       job_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [OUT_BITS-1:0] smoothed,
	output logic                       end_of_waveform
);

	localparam logic [1:0] PH_PASS = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_MID  = 2'd2;
	localparam logic [1:0] PH_TAIL = 2'd3;

	localparam int OPW = $clog2(OQ_DEPTH);
	localparam int OCW = $clog2(OQ_DEPTH + 1);

	// sequencer
	logic       started_q;
	logic [1:0] phase_q;
	logic [2:0] idx_q;
	logic [1:0] cur_ph, nxt_ph;
	logic [2:0] cur_idx, nxt_idx;
	logic [2:0] hmax;
	logic       issue, fin, eow_d;
	logic [OCW-1:0] cred_q;

	logic signed [COEF_BITS-1:0] cv  [TAPS];
	logic signed [COEF_BITS-1:0] row [TAPS];
	logic [DEN_BITS-1:0]         den_d;

	// datapath stages
	logic                              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [COEF_BITS-1:0]       c_s1 [TAPS];
	logic signed [SAMPLE_BITS-1:0]     w_s1 [TAPS];
	logic signed [PROD_BITS-1:0]       p_s2 [TAPS];
	logic [DEN_BITS-1:0]               den_s1, den_s2, den_s3, den_s4, den_s5;
	logic                              eow_s1, eow_s2, eow_s3, eow_s4, eow_s5, eow_s6;
	logic                              neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MAG_BITS-1:0]               mag_s3, mag_s4;
	logic [MAG_BITS-1:0]               a_s4, a_s5, a_s6;
	logic [DEN_BITS-1:0]               b_s5;
	logic [V_BITS-1:0]                 q2_s6;

	logic signed [SUM_BITS-1:0]        acc;
	logic [MAG_BITS+K1:0]              pr1;
	logic [MAG_BITS+DEN_BITS-1:0]      ad;
	logic [MAG_BITS-1:0]               rem;
	logic [V_BITS-1:0]                 vv, vs;
	logic [V_BITS+K2:0]                pr2;
	logic [Q_BITS-1:0]                 q, mq;
	res_t                              res;

	// result queue
	res_t           oq_q [OQ_DEPTH];
	logic [OPW-1:0] owr_q, ord_q;
	logic [OCW-1:0] ocnt_q;
	logic           opop;

	assign hmax    = job.sz ? 3'd2 : 3'd1;
	assign issue   = !job_empty && (cred_q < OCW'(OQ_DEPTH));
	assign job_pop = issue && fin;

	always_comb begin
		cur_ph  = started_q ? phase_q : (job.pass ? PH_PASS : (job.head ? PH_HEAD : PH_MID));
		cur_idx = started_q ? idx_q : 3'd0;
		nxt_ph  = cur_ph;
		nxt_idx = cur_idx;
		fin     = 1'b0;
		eow_d   = 1'b0;
		case (cur_ph)
			PH_PASS: begin
				fin     = cur_idx == job.npass - 3'd1;
				eow_d   = fin;
				nxt_idx = cur_idx + 3'd1;
			end
			PH_HEAD: begin
				if (cur_idx == hmax) begin
					nxt_ph  = PH_MID;
					nxt_idx = 3'd0;
				end else begin
					nxt_idx = cur_idx + 3'd1;
				end
			end
			PH_MID: begin
				fin     = !job.last;
				nxt_ph  = PH_TAIL;
				nxt_idx = hmax;
			end
			PH_TAIL: begin
				fin     = cur_idx == 3'd0;
				eow_d   = fin;
				nxt_idx = cur_idx - 3'd1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// coefficient vector aligned to window positions
	always_comb begin
		for (int p = 0; p < TAPS; p++) begin
			cv[p]  = '0;
			row[p] = (cur_ph == PH_MID) ? MID_COEF[job.ord][job.sz][p]
			                            : HEAD_COEF[job.ord][job.sz][cur_idx[1:0]][p];
		end
		den_d = (cur_ph == PH_MID) ? MID_DEN[job.ord][job.sz]
		                           : HEAD_DEN[job.ord][job.sz][cur_idx[1:0]];
		case (cur_ph)
			PH_PASS: begin
				den_d = DEN_BITS'(1);
				for (int p = 0; p < TAPS; p++) begin
					if (4'(p) == 4'd7 - {1'b0, job.npass} + {1'b0, cur_idx}) begin
						cv[p] = COEF_BITS'(1);
					end
				end
			end
			PH_TAIL: begin
				for (int p = 0; p < TAPS; p++) begin
					cv[p] = row[TAPS-1-p];
				end
			end
			default: begin
				if (job.sz) begin
					for (int p = 0; p < TAPS; p++) begin
						cv[p] = row[p];
					end
				end else begin
					for (int p = 0; p < 5; p++) begin
						cv[p+2] = row[p];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q   <= PH_PASS;
			idx_q     <= '0;
			cred_q    <= '0;
		end else begin
			if (issue) begin
				started_q <= !fin;
				phase_q   <= nxt_ph;
				idx_q     <= nxt_idx;
			end
			cred_q <= cred_q + OCW'(issue) - OCW'(opop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		acc = '0;
		for (int p = 0; p < TAPS; p++) begin
			acc = acc + SUM_BITS'(p_s2[p]);
		end
		pr1 = (MAG_BITS+K1+1)'(mag_s3 >> den_shift(den_s3)) *
		      (MAG_BITS+K1+1)'(recip1(den_odd(den_s3)));
		ad  = (MAG_BITS+DEN_BITS)'(a_s4) * (MAG_BITS+DEN_BITS)'(den_s4);
		rem = mag_s4 - ad[MAG_BITS-1:0];
		vv  = (V_BITS'(b_s5) << (FRAC_BITS + 1)) + V_BITS'(den_s5);
		vs  = vv >> (den_shift(den_s5) + 2'd1);
		pr2 = (V_BITS+K2+1)'(vs) * (V_BITS+K2+1)'(recip2(den_odd(den_s5)));
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < TAPS; p++) begin
			c_s1[p] <= cv[p];
			w_s1[p] <= job.win[p];
			p_s2[p] <= c_s1[p] * w_s1[p];
		end
		den_s1 <= den_d;
		eow_s1 <= eow_d;
		den_s2 <= den_s1;
		eow_s2 <= eow_s1;
		neg_s3 <= acc < 0;
		mag_s3 <= MAG_BITS'((acc < 0) ? -acc : acc);
		den_s3 <= den_s2;
		eow_s3 <= eow_s2;
		a_s4   <= pr1[K1 +: MAG_BITS];
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		den_s4 <= den_s3;
		eow_s4 <= eow_s3;
		b_s5   <= rem[DEN_BITS-1:0];
		a_s5   <= a_s4;
		neg_s5 <= neg_s4;
		den_s5 <= den_s4;
		eow_s5 <= eow_s4;
		q2_s6  <= pr2[K2 +: V_BITS];
		a_s6   <= a_s5;
		neg_s6 <= neg_s5;
		eow_s6 <= eow_s5;
	end

	// rounded magnitude, saturated, then sign applied
	always_comb begin
		q  = (Q_BITS'(a_s6) << FRAC_BITS) + Q_BITS'(q2_s6);
		mq = q;
		if (neg_s6 && q > (Q_BITS'(1) << (OUT_BITS - 1))) begin
			mq = Q_BITS'(1) << (OUT_BITS - 1);
		end else if (!neg_s6 && q > ((Q_BITS'(1) << (OUT_BITS - 1)) - Q_BITS'(1))) begin
			mq = (Q_BITS'(1) << (OUT_BITS - 1)) - Q_BITS'(1);
		end
		res.smoothed = neg_s6 ? -$signed(mq[OUT_BITS-1:0]) : $signed(mq[OUT_BITS-1:0]);
		res.eow      = eow_s6;
	end

	assign empty           = ocnt_q == '0;
	assign opop            = pop && !empty;
	assign smoothed        = oq_q[ord_q].smoothed;
	assign end_of_waveform = oq_q[ord_q].eow;

	always_ff @(posedge clk) begin
		if (v_s6) begin
			oq_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s6) begin
				owr_q <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + OCW'(v_s6) - OCW'(opop);
		end
	end

endmodule

// ===== rtl/core/polynomial_smoothing_filter_top.sv =====
// polynomial smoothing filter, 5- or 7-point least-squares fit
// input channel: sample and last_sample, accepted on push while full is low
// result channel: smoothed (8 fraction bits) and end_of_waveform, shown while
//   empty is low and taken on pop
// config: wr_en/wr_index/wr_data, index 0 window_points, index 1 fit_order
// throughput: one sample per cycle while full is low; the back end issues one
//   result per cycle while a job is queued and the result queue has room, so
//   the first and last sample of a waveform take one issue per result (up to
//   seven), set by the single shared filter pipeline
// path: job queue, six-stage multiply/sum/divide pipeline, result queue
// stalls: a 2-entry job queue separates front and back; the back end only
//   issues when the 16-entry result queue has room, so pop held low backs up
//   into full without dropping any beat
// reset: clears window, sample count, queues and both config registers
module polynomial_smoothing_filter_top import psf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                       last_sample,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [OUT_BITS-1:0] smoothed,
	output logic                       end_of_waveform,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [1:0]                 wr_data
);

	logic       window_points_q;
	logic [1:0] fit_order_q;
	logic       jq_push, jq_pop, jq_empty;
	job_t       jq_din, jq_dout;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_points_q <= 1'b0;
			fit_order_q     <= 2'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_WINDOW_POINTS: window_points_q <= wr_data[0];
				REG_FIT_ORDER:     fit_order_q     <= wr_data;
				default:           window_points_q <= window_points_q;
			endcase
		end
	end

	// front: sample window and output schedule
	psf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.last_sample (last_sample),
		.sz          (window_points_q),
		.ord         (fit_order_q),
		.jq_push     (jq_push),
		.jq_din      (jq_din)
	);

	// decoupling queue of window snapshots
	psf_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.full   (full),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.empty  (jq_empty)
	);

	// back: result sequencer, filter pipeline and result queue
	psf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job             (jq_dout),
		.job_empty       (jq_empty),
		.job_pop         (jq_pop),
		.empty           (empty),
		.pop             (pop),
		.smoothed        (smoothed),
		.end_of_waveform (end_of_waveform)
	);

endmodule

// ===== rtl/core/psf_checker.sv =====
module psf_checker import psf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic signed [OUT_BITS-1:0] smoothed,
	input logic                       end_of_waveform
);

	// largest filter gain is 68/42 on a full-scale sample
	localparam logic signed [OUT_BITS-1:0] OUT_HI = 25'sd13631488;
	localparam logic signed [OUT_BITS-1:0] OUT_LO = -25'sd13631488;

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push && !full) begin
			seen_q <= 1'b1;
		end
	end

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(smoothed) && $stable(end_of_waveform))
		else $error("result beat changed while stalled");

	// no beat before the first sample
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> empty)
		else $error("result beat without any sample");

	// filter gain bounds the output
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (smoothed <= OUT_HI) && (smoothed >= OUT_LO))
		else $error("smoothed value out of range");

endmodule

bind polynomial_smoothing_filter_top psf_checker u_chk (.*);
